// ===== sv/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// Shared constants, register codes and item type of the pixel running
// average core.
// ----------------------------------------------------------------------------
`default_nettype none

package pra_pkg;

  localparam int MAX_SAMPLES   = 65536;
  localparam int FRACTION_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int AVG_W    = SAMPLE_W + FRACTION_BITS;
  localparam int WEIGHT_W = 17;
  localparam int WFRAC_W  = 16;
  localparam int FRAME_W  = 17;
  localparam int PROD_W   = AVG_W + WEIGHT_W;
  localparam int RND_W    = AVG_W + 1 - FRACTION_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(6554);
  localparam logic [FRAME_W-1:0]  FRAME_RESET  =
    FRAME_W'((65536 < MAX_SAMPLES) ? 65536 : MAX_SAMPLES);
  localparam logic [FRAME_W-1:0]  FRAME_MAX    = FRAME_W'(MAX_SAMPLES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT = 2'd0,
    REG_DEPTH  = 2'd1,
    REG_FRAME  = 2'd2
  } pra_reg_t;

  // One sample on its way through the update pipeline.
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic [IDX_W-1:0]    idx;
    logic                first;
    logic                last;
    logic                depth;
  } pra_item_t;

endpackage

`default_nettype wire

// ===== sv/pra_pipe.sv =====
// ----------------------------------------------------------------------------
// pra_pipe
// Average store and blend pipeline: read, difference, multiply, scale,
// write back, round and saturate, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_pipe (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  pra_pkg::pra_item_t          in_item,
  input  wire  [pra_pkg::WEIGHT_W-1:0]      weight,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [pra_pkg::SAMPLE_W-1:0]      out_average,
  output logic                              out_last,
  output logic                              busy
);

  logic [pra_pkg::AVG_W-1:0] mem [pra_pkg::MAX_SAMPLES];

  pra_pkg::pra_item_t s1_item, s2_item, s3_item, s4_item;
  logic v1, v2, v3, v4, v5;
  logic [pra_pkg::AVG_W-1:0]  s1_avg, s2_avg, s3_avg, s4_avg;
  logic [pra_pkg::AVG_W-1:0]  s2_mag;
  logic [pra_pkg::PROD_W-1:0] s3_prod;
  logic [pra_pkg::AVG_W-1:0]  s4_step;
  logic s2_neg, s3_neg, s4_neg;
  logic [pra_pkg::AVG_W-1:0]  s5_avg;
  logic s5_last, s5_depth;

  logic ld1, ld2, ld3, ld4, ld5, ld6;
  logic hazard, accept;

  logic [pra_pkg::AVG_W-1:0]  fix1, fix4;
  logic                       neg1;
  logic [pra_pkg::PROD_W-1:0] prod_rnd;
  logic [pra_pkg::AVG_W-1:0]  new_avg;
  logic [pra_pkg::RND_W-1:0]  rnd;
  logic [pra_pkg::RND_W-1:0]  maxval;

  // A stage loads when it is empty or its content moves on.
  assign ld6 = !out_valid || out_ready;
  assign ld5 = !v5 || ld6;
  assign ld4 = !v4 || ld5;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;

  // Any transaction still inside the pipeline.
  assign busy = v1 || v2 || v3 || v4 || v5 || out_valid;

  // Hold a reading item back while an older update of its entry is in flight.
  assign hazard = !in_item.first &&
                  ((v1 && s1_item.idx == in_item.idx) ||
                   (v2 && s2_item.idx == in_item.idx) ||
                   (v3 && s3_item.idx == in_item.idx) ||
                   (v4 && s4_item.idx == in_item.idx));

  assign in_ready = ld1 && !hazard;
  assign accept   = in_valid && in_ready;

  always_comb begin
    fix1 = {s1_item.smp, {pra_pkg::FRACTION_BITS{1'b0}}};
    neg1 = fix1 < s1_avg;
    fix4 = {s4_item.smp, {pra_pkg::FRACTION_BITS{1'b0}}};
    prod_rnd = s3_prod + pra_pkg::PROD_W'(1 << (pra_pkg::WFRAC_W - 1));
    if (s4_item.first) begin
      new_avg = fix4;
    end else if (s4_neg) begin
      new_avg = s4_avg - s4_step;
    end else begin
      new_avg = s4_avg + s4_step;
    end
    rnd = pra_pkg::RND_W'(({1'b0, s5_avg} +
          (pra_pkg::AVG_W + 1)'(1 << (pra_pkg::FRACTION_BITS - 1)))
          >> pra_pkg::FRACTION_BITS);
    maxval = s5_depth ? pra_pkg::RND_W'(16'hFFFF) : pra_pkg::RND_W'(8'hFF);
  end

  // Store: registered read on accept, write back as stage 4 moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_avg <= mem[in_item.idx];
    end
    if (v4 && ld5) begin
      mem[s4_item.idx] <= new_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1) v1 <= accept;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && accept) begin
      s1_item <= in_item;
    end
    if (ld2 && v1) begin
      s2_item <= s1_item;
      s2_avg  <= s1_avg;
      s2_neg  <= neg1;
      s2_mag  <= neg1 ? (s1_avg - fix1) : (fix1 - s1_avg);
    end
    if (ld3 && v2) begin
      s3_item <= s2_item;
      s3_avg  <= s2_avg;
      s3_neg  <= s2_neg;
      s3_prod <= pra_pkg::PROD_W'(s2_mag) * pra_pkg::PROD_W'(weight);
    end
    if (ld4 && v3) begin
      s4_item <= s3_item;
      s4_avg  <= s3_avg;
      s4_neg  <= s3_neg;
      s4_step <= prod_rnd[pra_pkg::WFRAC_W +: pra_pkg::AVG_W];
    end
    if (ld5 && v4) begin
      s5_avg   <= new_avg;
      s5_last  <= s4_item.last;
      s5_depth <= s4_item.depth;
    end
    if (ld6 && v5) begin
      out_average <= pra_pkg::SAMPLE_W'((rnd > maxval) ? maxval : rnd);
      out_last    <= s5_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pixel_running_average_core.sv =====
// Path: an accepted input transaction moves through the pipeline stages to its output transaction.
// Throughput: one sample per cycle while the output is not stalled; a sample waits while an older update of its
//   store entry is in flight, so frames shorter than 5 samples run below full rate.
// Config: a write waits for an empty pipeline and holds off input for that cycle.
// Reset: synchronous; clears the pipeline, restores the register defaults and
//   restarts at position 0 in first-frame mode. The store itself is not cleared.
// ----------------------------------------------------------------------------
// pixel_running_average_core
// Per-sample exponential running average over a video stream with a frame
// store of fixed-point averages.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_running_average_core (
  input  wire                                 clk,
  input  wire                                 rst,
  // Input stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [pra_pkg::SAMPLE_W-1:0]        s_axis_tdata,   // [15:0] sample
  // Output stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [pra_pkg::SAMPLE_W-1:0]        m_axis_tdata,   // [15:0] average
  output logic                                m_axis_tlast,   // frame_end
  // Configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [pra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [pra_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [pra_pkg::WEIGHT_W-1:0] weight;
  logic                         sample_depth;
  logic [pra_pkg::FRAME_W-1:0]  frame_samples;
  logic [pra_pkg::IDX_W-1:0]    position;
  logic                         first_frame;

  logic                         cfg_write;
  logic                         in_accept;
  logic                         frame_end;
  logic [pra_pkg::FRAME_W-1:0]  pos_inc;
  pra_pkg::pra_item_t           item;
  logic                         pipe_ready;
  logic                         pipe_busy;

  // Take a configuration write only while no transaction is in flight, and
  // hold off the input stream in the cycle the write lands.
  assign cfg_ready = !pipe_busy;
  assign cfg_write = cfg_valid && cfg_ready;

  assign s_axis_tready = pipe_ready && !cfg_write;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Last sample of the frame: next position would reach the frame size.
  assign pos_inc   = pra_pkg::FRAME_W'(position) + pra_pkg::FRAME_W'(1);
  assign frame_end = pos_inc >= frame_samples;

  // Build the item: drop the upper byte in 8-bit mode.
  always_comb begin
    item.smp   = sample_depth ? s_axis_tdata
                              : {{(pra_pkg::SAMPLE_W-8){1'b0}}, s_axis_tdata[7:0]};
    item.idx   = position;
    item.first = first_frame;
    item.last  = frame_end;
    item.depth = sample_depth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight        <= pra_pkg::WEIGHT_RESET;
      sample_depth  <= 1'b0;
      frame_samples <= pra_pkg::FRAME_RESET;
      position      <= '0;
      first_frame   <= 1'b1;
    end else if (cfg_write) begin
      // Any accepted write restarts the stream; out-of-range values are dropped.
      unique case (cfg_index)
        pra_pkg::REG_WEIGHT: begin
          if (pra_pkg::WEIGHT_W'(cfg_data) <= pra_pkg::WEIGHT_ONE) begin
            weight      <= pra_pkg::WEIGHT_W'(cfg_data);
            position    <= '0;
            first_frame <= 1'b1;
          end
        end
        pra_pkg::REG_DEPTH: begin
          sample_depth <= cfg_data[0];
          position     <= '0;
          first_frame  <= 1'b1;
        end
        pra_pkg::REG_FRAME: begin
          if (cfg_data != '0 && pra_pkg::FRAME_W'(cfg_data) <= pra_pkg::FRAME_MAX) begin
            frame_samples <= pra_pkg::FRAME_W'(cfg_data);
            position      <= '0;
            first_frame   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      // Advance the position; wrap and leave first-frame mode at frame end.
      if (frame_end) begin
        position    <= '0;
        first_frame <= 1'b0;
      end else begin
        position    <= pos_inc[pra_pkg::IDX_W-1:0];
      end
    end
  end

  pra_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid && !cfg_write),
    .in_ready    (pipe_ready),
    .in_item     (item),
    .weight      (weight),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_average (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .busy        (pipe_busy)
  );

endmodule

`default_nettype wire

// ===== sv/pra_checker.sv =====
// ----------------------------------------------------------------------------
// pra_checker
// Port-level checks of the pixel running average core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pra_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [pra_pkg::SAMPLE_W-1:0]    m_axis_tdata,
  input wire                            m_axis_tlast
);

  logic [3:0] inflight;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Count transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + 4'd1;
    end else if (!in_acc && out_acc) begin
      inflight <= inflight - 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> inflight != 4'd0)
    else $error("output without a pending input");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'd6)
    else $error("more transactions in flight than pipeline stages");

endmodule

bind pixel_running_average_core pra_checker u_pra_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/tb_pixel_running_average_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_running_average_core
// Self-checking bench for the pixel running average core. A behavioral copy
// of the frame store predicts every output transaction. A directed part
// covers register defaults, weight and frame-length extremes, ignored writes
// and rounding. A long random part then runs many register settings with
// random gaps on both stream sides.
// ----------------------------------------------------------------------------

module tb_pixel_running_average_core;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int IDLE_MAX      = 8;
  // Settling time once every owed average is in, before touching registers.
  localparam int SETTLE_CYCLES = 12;
  // Slowest correct item: the largest sender gap, the largest receiver stall,
  // the pipeline passage and a short-frame hazard stall. Take that many times over.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int MAX_REPORTS   = 10;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [pra_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [pra_pkg::SAMPLE_W-1:0] average;
    logic                         frame_end;
  } avg_result_t;

  // --------------------------------------------------------------------------
  // Block ports; the inputs are known from time zero
  // --------------------------------------------------------------------------
  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pra_pkg::SAMPLE_W-1:0]   s_axis_tdata  = '0;    // [15:0] sample
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pra_pkg::SAMPLE_W-1:0]   m_axis_tdata;          // [15:0] average
  logic                           m_axis_tlast;          // frame_end
  logic                           cfg_valid     = 1'b0;
  logic                           cfg_ready;
  logic [pra_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [pra_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the frame store and the registers
  // --------------------------------------------------------------------------
  logic [pra_pkg::AVG_W-1:0]    avg_store [pra_pkg::MAX_SAMPLES];
  int unsigned                  frame_pos     = 0;
  bit                           first_frame_q = 1'b1;
  logic [pra_pkg::WEIGHT_W-1:0] blend_weight  = pra_pkg::WEIGHT_RESET;
  bit                           wide_samples  = 1'b0;
  int unsigned                  frame_len     = pra_pkg::FRAME_RESET;

  avg_result_t avg_expect [$];   // averages still owed by the block
  avg_result_t avg_want;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  bit          idle_on        = 1'b1;
  int          rx_hold        = 0;
  int          rx_gap;

  pixel_running_average_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Idle cycles before the next transaction on either side; zero in
  // stretches where idling is switched off.
  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, IDLE_MAX) : 0;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: update the store entry for this position and queue the
  // average the block has to return for the sample.
  // --------------------------------------------------------------------------
  task automatic predict_average(input logic [pra_pkg::SAMPLE_W-1:0] smp);
    logic [pra_pkg::SAMPLE_W-1:0] ceiling;
    logic [pra_pkg::SAMPLE_W-1:0] s;
    logic [pra_pkg::AVG_W-1:0]    s_fix;
    logic [pra_pkg::AVG_W-1:0]    prev;
    logic [pra_pkg::AVG_W-1:0]    next;
    logic [63:0]                  step;
    logic [pra_pkg::AVG_W:0]      rounded;
    avg_result_t                  res;
    ceiling = wide_samples ? 16'hFFFF : 16'h00FF;
    // Drop the upper byte in 8-bit mode.
    s = smp & ceiling;
    s_fix = pra_pkg::AVG_W'(s) << pra_pkg::FRACTION_BITS;
    if (first_frame_q) begin
      // First frame: load the entry with the sample itself.
      next = s_fix;
    end else begin
      prev = avg_store[frame_pos];
      // Scale the distance by the weight, round half away from zero.
      if (s_fix >= prev) begin
        step = (64'(s_fix - prev) * 64'(blend_weight) +
                (64'(1) << (pra_pkg::WFRAC_W - 1))) >> pra_pkg::WFRAC_W;
        next = prev + step[pra_pkg::AVG_W-1:0];
      end else begin
        step = (64'(prev - s_fix) * 64'(blend_weight) +
                (64'(1) << (pra_pkg::WFRAC_W - 1))) >> pra_pkg::WFRAC_W;
        next = prev - step[pra_pkg::AVG_W-1:0];
      end
    end
    avg_store[frame_pos] = next;
    // Round to nearest with halves up, then clamp to the sample depth.
    rounded = ({1'b0, next} + (pra_pkg::AVG_W + 1)'(1 << (pra_pkg::FRACTION_BITS - 1)))
              >> pra_pkg::FRACTION_BITS;
    res.average   = (rounded > ceiling) ? ceiling : rounded[pra_pkg::SAMPLE_W-1:0];
    res.frame_end = (frame_pos + 1 >= frame_len);
    if (res.frame_end) begin
      frame_pos     = 0;
      first_frame_q = 1'b0;
    end else begin
      frame_pos++;
    end
    avg_expect.push_back(res);
  endtask

  // Mirror a register write; out-of-range values leave everything alone,
  // any accepted write restarts the stream in first-frame mode.
  task automatic apply_reg(input logic [pra_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pra_pkg::CFG_DATA_W-1:0] data);
    bit taken;
    taken = 1'b0;
    case (idx)
      pra_pkg::REG_WEIGHT: begin
        if (data <= pra_pkg::WEIGHT_ONE) begin
          blend_weight = data[pra_pkg::WEIGHT_W-1:0];
          taken        = 1'b1;
        end
      end
      pra_pkg::REG_DEPTH: begin
        wide_samples = data[0];
        taken        = 1'b1;
      end
      pra_pkg::REG_FRAME: begin
        if (data != 0 && data <= pra_pkg::FRAME_MAX) begin
          frame_len = data;
          taken     = 1'b1;
        end
      end
      default: ;
    endcase
    if (taken) begin
      frame_pos     = 0;
      first_frame_q = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Send one sample: idle for a drawn gap, then hold the transaction until
  // the block takes it. Keep tvalid high when no gap follows.
  task automatic send_sample(input logic [pra_pkg::SAMPLE_W-1:0] smp);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk); while (!s_axis_tready);
    predict_average(smp);
  endtask

  // Drop the input stream and wait until every owed average has arrived,
  // then let the pipeline settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (avg_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transaction; call only while the block is idle.
  task automatic program_reg(input logic [pra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pra_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls on tready, one draw per transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rx_gap = draw_gap();
      rx_hold       <= rx_gap;
      m_axis_tready <= (rx_gap == 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold       <= 0;
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest owed average.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (avg_expect.size() == 0) begin
        note_mismatch("unexpected transaction, average", '0, m_axis_tdata);
      end else begin
        avg_want = avg_expect.pop_front();
        if (m_axis_tdata !== avg_want.average)
          note_mismatch("average", avg_want.average, m_axis_tdata);
        if (m_axis_tlast !== avg_want.frame_end)
          note_mismatch("frame_end", avg_want.frame_end, m_axis_tlast);
      end
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** pixel_running_average_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: 8-bit samples, long frame, so everything stays in the
  // first frame and each average is the sample; upper bits must be ignored.
  task automatic test_reset_defaults();
    send_sample(16'h0000);
    send_sample(16'h00FF);
    send_sample(16'hFFFF);
    send_sample(16'hAB12);
  endtask

  // Weight of 1.0 on 16-bit samples: the second frame follows the input.
  task automatic test_full_weight();
    wait_idle();
    program_reg(pra_pkg::REG_DEPTH, 17'd1);
    program_reg(pra_pkg::REG_FRAME, 17'd2);
    program_reg(pra_pkg::REG_WEIGHT, pra_pkg::WEIGHT_ONE);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8001);
  endtask

  // Out-of-range writes and the unmapped index: the stream carries on
  // mid-frame with the old weight, no restart.
  task automatic test_rejected_writes();
    wait_idle();
    program_reg(pra_pkg::REG_WEIGHT, 17'(pra_pkg::WEIGHT_ONE) + 17'd1);
    program_reg(pra_pkg::REG_WEIGHT, 17'h1FFFF);
    program_reg(pra_pkg::REG_FRAME, 17'd0);
    program_reg(pra_pkg::REG_FRAME, 17'(pra_pkg::FRAME_MAX) + 17'd1);
    program_reg(REG_UNMAPPED, 17'h1FFFF);
    send_sample(16'h1234);
    send_sample(16'h4321);
  endtask

  // Weight of zero: after the first frame the averages must not move.
  task automatic test_zero_weight();
    wait_idle();
    program_reg(pra_pkg::REG_WEIGHT, 17'd0);
    program_reg(pra_pkg::REG_DEPTH, 17'd0);
    send_sample(16'h0010);
    send_sample(16'h00F0);
    send_sample(16'h00FF);
    send_sample(16'h0000);
  endtask

  // One-sample frames at weight 0.5: every transaction ends a frame, the
  // same entry is hit back to back, and 127.5 must round up to 128.
  task automatic test_single_sample_frames();
    wait_idle();
    program_reg(pra_pkg::REG_FRAME, 17'd1);
    program_reg(pra_pkg::REG_WEIGHT, 17'd32768);
    send_sample(16'h00FF);
    send_sample(16'h0100);
    send_sample(16'h01FF);
    send_sample(16'h0003);
  endtask

  // Largest frame: a few samples, no frame end expected.
  task automatic test_largest_frame();
    wait_idle();
    program_reg(pra_pkg::REG_FRAME, pra_pkg::FRAME_MAX);
    send_sample(16'h0055);
    send_sample(16'h00AA);
    send_sample(16'h0080);
  endtask

  // Random phases: reprogram while idle, then run a few frames of samples.
  task automatic test_random_stream();
    int                             sent;
    int                             phase;
    int                             n;
    int                             pause_at;
    int                             pick;
    int                             style;
    int unsigned                    fs;
    logic [pra_pkg::CFG_IDX_W-1:0]  idx;
    logic [pra_pkg::CFG_DATA_W-1:0] val;
    logic [pra_pkg::SAMPLE_W-1:0]   level;
    logic [pra_pkg::SAMPLE_W-1:0]   smp;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 15);
        idx  = (pick == 15) ? REG_UNMAPPED : pra_pkg::CFG_IDX_W'(pick % 3);
        pick = $urandom_range(0, 15);
        case (idx)
          pra_pkg::REG_WEIGHT: begin
            case (pick)
              0:       val = 17'd0;
              1:       val = pra_pkg::WEIGHT_ONE;
              2:       val = 17'd1;
              3:       val = 17'($urandom_range(65537, 131071));
              default: val = 17'($urandom_range(0, 65536));
            endcase
          end
          pra_pkg::REG_DEPTH: val = 17'($urandom_range(0, 131071));
          pra_pkg::REG_FRAME: begin
            case (pick)
              0:       val = 17'd0;
              1:       val = 17'($urandom_range(65537, 131071));
              2:       val = 17'd1;
              3, 4:    val = 17'($urandom_range(17, 80));
              5:       val = 17'($urandom_range(81, 400));
              default: val = 17'($urandom_range(1, 16));
            endcase
          end
          default: val = 17'($urandom);
        endcase
        program_reg(idx, val);
      end
      // Cover whole frames plus a partial one; huge frames get a short burst.
      fs = frame_len;
      if (fs > 400)
        n = $urandom_range(20, 200);
      else
        n = fs * ((fs <= 64) ? $urandom_range(2, 5) : 2) + $urandom_range(0, fs - 1);
      // Trim the last phase so the run ends near the planned item count.
      if (n > RANDOM_ITEMS - sent)
        n = RANDOM_ITEMS - sent;
      // Hold off mid-phase until the block has drained, always in phase 0.
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
      style = $urandom_range(0, 2);
      level = 16'($urandom);
      for (int i = 0; i < n; i++) begin
        if (i == pause_at)
          wait_idle();
        case (style)
          0:       smp = 16'($urandom);
          1:       smp = level ^ 16'($urandom_range(0, 15));
          default: smp = {($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00,
                          ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00};
        endcase
        send_sample(smp);
      end
      sent += n;
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_full_weight();
    test_rejected_writes();
    test_zero_weight();
    test_single_sample_frames();
    test_largest_frame();
    test_random_stream();
    idle_on = 1'b1;
    wait_idle();
    if (mismatch_count == 0 && avg_expect.size() == 0) begin
      $display("** pixel_running_average_core: PASSED **");
    end else begin
      $display("** pixel_running_average_core: FAILED **");
    end
    $finish;
  end

endmodule
